// ===== rtl/core/apt_pkg.sv =====
// Shared types and codes for the affine point transform unit.
package apt_pkg;

	localparam logic [2:0] OP_TRANSFORM   = 3'd0;
	localparam logic [2:0] OP_DTRANSFORM  = 3'd1;
	localparam logic [2:0] OP_ITRANSFORM  = 3'd2;
	localparam logic [2:0] OP_IDTRANSFORM = 3'd3;
	localparam logic [2:0] OP_INVERT      = 3'd4;

	localparam logic [2:0] REG_XX = 3'd0;
	localparam logic [2:0] REG_YX = 3'd1;
	localparam logic [2:0] REG_XY = 3'd2;
	localparam logic [2:0] REG_YY = 3'd3;
	localparam logic [2:0] REG_TX = 3'd4;
	localparam logic [2:0] REG_TY = 3'd5;

	typedef enum logic [2:0] {
		UK_FWD_T,
		UK_FWD_D,
		UK_INV_T,
		UK_INV_D,
		UK_INV0,
		UK_INV1,
		UK_INV2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               last;
	} uop_t;

	typedef struct packed {
		logic signed [31:0] xx;
		logic signed [31:0] yx;
		logic signed [31:0] xy;
		logic signed [31:0] yy;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
	} matrix_t;

	typedef struct packed {
		logic v;
		logic negx;
		logic negy;
		logic satx;
		logic saty;
		logic sing;
		logic last;
	} tag_t;

endpackage

// ===== rtl/core/apt_front.sv =====
// Input hold stage and op expansion into micro items.
module apt_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [2:0]         s_tuser,  // op
	input  logic [63:0]        s_tdata,  // x_in, y_in
	input  logic               ce,
	output logic               uop_valid,
	output apt_pkg::uop_t      uop
);
	import apt_pkg::*;

	logic        hv_q;
	logic [2:0]  hop_q;
	logic [31:0] hx_q;
	logic [31:0] hy_q;
	logic [1:0]  ph_q;
	logic        is_inv;
	logic        done;
	logic        consume;

	assign is_inv   = (hop_q == OP_INVERT);
	assign done     = !is_inv || (ph_q == 2'd2);
	assign consume  = hv_q && ce && done;
	assign s_tready = !hv_q || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= 1'b0;
			ph_q <= 2'd0;
		end else begin
			if (s_tvalid && s_tready)
				hv_q <= 1'b1;
			else if (consume)
				hv_q <= 1'b0;
			if (hv_q && ce)
				ph_q <= done ? 2'd0 : ph_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			hop_q <= s_tuser;
			hx_q  <= s_tdata[31:0];
			hy_q  <= s_tdata[63:32];
		end
	end

	always_comb begin
		uop.x     = hx_q;
		uop.y     = hy_q;
		uop.last  = done;
		uop_valid = hv_q;
		case (hop_q)
			OP_TRANSFORM:   uop.kind = UK_FWD_T;
			OP_DTRANSFORM:  uop.kind = UK_FWD_D;
			OP_ITRANSFORM:  uop.kind = UK_INV_T;
			OP_IDTRANSFORM: uop.kind = UK_INV_D;
			OP_INVERT: begin
				case (ph_q)
					2'd0:    uop.kind = UK_INV0;
					2'd1:    uop.kind = UK_INV1;
					default: uop.kind = UK_INV2;
				endcase
			end
			default: begin
				uop.kind  = UK_FWD_D;
				uop_valid = 1'b0;
			end
		endcase
	end

	a_phase_inv: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q != 2'd0 |-> hv_q && hop_q == OP_INVERT)
		else $error("phase advanced on a non-invert item");

endmodule

// ===== rtl/core/apt_div.sv =====
// Restoring divider lane, one quotient bit per pipeline stage.
module apt_div #(
	parameter int RW    = 99,
	parameter int DW2   = 67,
	parameter int STEPS = 31
) (
	input  logic             clk,
	input  logic             ce,
	input  logic [RW-1:0]    num,
	input  logic [DW2-1:0]   den2,
	output logic [STEPS-1:0] quo
);
	logic [RW-1:0]    rem_s [STEPS+1];
	logic [DW2-1:0]   den_s [STEPS+1];
	logic [STEPS-1:0] q_s   [STEPS+1];

	assign rem_s[0] = num;
	assign den_s[0] = den2;
	assign q_s[0]   = '0;
	assign quo      = q_s[STEPS];

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		logic [RW-1:0] trial;
		assign trial = RW'(den_s[g]) << (STEPS - 1 - g);
		always_ff @(posedge clk) begin
			if (ce) begin
				den_s[g+1] <= den_s[g];
				if (rem_s[g] >= trial) begin
					rem_s[g+1] <= rem_s[g] - trial;
					q_s[g+1]   <= {q_s[g][STEPS-2:0], 1'b1};
				end else begin
					rem_s[g+1] <= rem_s[g];
					q_s[g+1]   <= {q_s[g][STEPS-2:0], 1'b0};
				end
			end
		end
	end

endmodule

// ===== rtl/core/affine_point_transform_unit.sv =====
// Affine point transform unit: 2D transform, inverse transform and matrix inverse.
// Invert yields three results and holds its input until the last one issues.
// Throughput: one result and one input per cycle while m_tready does not stall.
// The depth is set by the 31-stage quotient pipeline after five arithmetic stages.
// Reset loads the identity matrix and empties the pipeline; stalls freeze all stages.
module affine_point_transform_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,  // op
	input  logic [63:0] s_tdata,  // x_in, y_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic        m_tuser,  // singular
	output logic        m_tlast,
	output logic [63:0] m_tdata   // x_out, y_out
);
	import apt_pkg::*;

	localparam int PW    = 66;
	localparam int SW    = 67;
	localparam int NW    = SW + 2 * FRAC_BITS;
	localparam int DW    = 66;
	localparam int STEPS = 31;
	localparam int RW    = (NW + 2 > DW + 1 + STEPS + 1) ? NW + 2 : DW + 1 + STEPS + 1;

	matrix_t m_q;
	logic    ce;
	logic    uop_valid;
	uop_t    uop;

	assign ce = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q.xx <= 32'sd1 <<< FRAC_BITS;
			m_q.yx <= '0;
			m_q.xy <= '0;
			m_q.yy <= 32'sd1 <<< FRAC_BITS;
			m_q.tx <= '0;
			m_q.ty <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_XX:  m_q.xx <= cfg_data;
				REG_YX:  m_q.yx <= cfg_data;
				REG_XY:  m_q.xy <= cfg_data;
				REG_YY:  m_q.yy <= cfg_data;
				REG_TX:  m_q.tx <= cfg_data;
				REG_TY:  m_q.ty <= cfg_data;
				default: ;
			endcase
		end
	end

	apt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.ce       (ce),
		.uop_valid(uop_valid),
		.uop      (uop)
	);

	// operand select
	logic signed [32:0] ex, ey, etx, ety, dx, dy;
	logic signed [32:0] pxx, pyx, pxy, pyy, nyx, nxy, nyy, nxx;
	logic signed [32:0] a0x, b0x, a1x, b1x, a0y, b0y, a1y, b1y;
	logic signed [SW-1:0] cx, cy;

	always_comb begin
		ex  = {uop.x[31], uop.x};
		ey  = {uop.y[31], uop.y};
		etx = {m_q.tx[31], m_q.tx};
		ety = {m_q.ty[31], m_q.ty};
		pxx = {m_q.xx[31], m_q.xx};
		pyx = {m_q.yx[31], m_q.yx};
		pxy = {m_q.xy[31], m_q.xy};
		pyy = {m_q.yy[31], m_q.yy};
		nxx = -pxx;
		nyx = -pyx;
		nxy = -pxy;
		nyy = -pyy;
		dx  = (uop.kind == UK_INV_T) ? ex - etx : ex;
		dy  = (uop.kind == UK_INV_T) ? ey - ety : ey;
		a0x = '0; b0x = '0; a1x = '0; b1x = '0;
		a0y = '0; b0y = '0; a1y = '0; b1y = '0;
		cx  = '0;
		cy  = '0;
		case (uop.kind)
			UK_FWD_T, UK_FWD_D: begin
				a0x = ex; b0x = pxx; a1x = ey; b1x = pxy;
				a0y = ex; b0y = pyx; a1y = ey; b1y = pyy;
				if (uop.kind == UK_FWD_T) begin
					cx = {{(SW-32){m_q.tx[31]}}, m_q.tx} << FRAC_BITS;
					cy = {{(SW-32){m_q.ty[31]}}, m_q.ty} << FRAC_BITS;
				end
			end
			UK_INV_T, UK_INV_D: begin
				a0x = dx; b0x = pyy; a1x = dy; b1x = nxy;
				a0y = dy; b0y = pxx; a1y = dx; b1y = nyx;
			end
			UK_INV0: begin
				a0x = 33'sd1; b0x = pyy;
				a0y = 33'sd1; b0y = nyx;
			end
			UK_INV1: begin
				a0x = 33'sd1; b0x = nxy;
				a0y = 33'sd1; b0y = pxx;
			end
			UK_INV2: begin
				a0x = ety; b0x = pxy; a1x = etx; b1x = nyy;
				a0y = etx; b0y = pyx; a1y = ety; b1y = nxx;
			end
			default: ;
		endcase
	end

	logic                 v_s1, last_s1;
	kind_t                kind_s1;
	logic signed [32:0]   a0x_s1, b0x_s1, a1x_s1, b1x_s1, a0y_s1, b0y_s1, a1y_s1, b1y_s1;
	logic signed [SW-1:0] cx_s1, cy_s1;

	logic                 v_s2, last_s2;
	kind_t                kind_s2;
	logic signed [PW-1:0] p0x_s2, p1x_s2, p0y_s2, p1y_s2, pd0_s2, pd1_s2;
	logic signed [SW-1:0] cx_s2, cy_s2;

	logic                 v_s3, last_s3;
	kind_t                kind_s3;
	logic signed [SW-1:0] sx_s3, sy_s3, det_s3;

	logic                 v_s4, last_s4, negx_s4, negy_s4, sing_s4;
	logic [RW-1:0]        npx_s4, npy_s4;
	logic [DW:0]          d2_s4;

	tag_t                 tag_s5;
	logic [RW-1:0]        npx_s5, npy_s5;
	logic [DW:0]          d2_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			tag_s5 <= '0;
		end else if (ce) begin
			v_s1     <= uop_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			tag_s5.v <= v_s4;
			tag_s5.negx <= negx_s4;
			tag_s5.negy <= negy_s4;
			tag_s5.sing <= sing_s4;
			tag_s5.last <= last_s4;
			tag_s5.satx <= npx_s4 >= (RW'(d2_s4) << STEPS);
			tag_s5.saty <= npy_s4 >= (RW'(d2_s4) << STEPS);
		end
	end

	// stage 4 combinational: scale, magnitudes, rounding offset
	logic signed [NW-1:0] nx_c, ny_c, nxn_c, nyn_c;
	logic [SW-1:0]        detn_c;
	logic [DW-1:0]        dmag_c;
	logic [NW-1:0]        mx_c, my_c;
	logic                 inv_c;

	always_comb begin
		inv_c = (kind_s3 != UK_FWD_T) && (kind_s3 != UK_FWD_D);
		nx_c  = {{(NW-SW){sx_s3[SW-1]}}, sx_s3};
		ny_c  = {{(NW-SW){sy_s3[SW-1]}}, sy_s3};
		case (kind_s3)
			UK_INV_T, UK_INV_D, UK_INV2: begin
				nx_c = nx_c <<< FRAC_BITS;
				ny_c = ny_c <<< FRAC_BITS;
			end
			UK_INV0, UK_INV1: begin
				nx_c = nx_c <<< (2 * FRAC_BITS);
				ny_c = ny_c <<< (2 * FRAC_BITS);
			end
			default: ;
		endcase
		nxn_c  = -nx_c;
		nyn_c  = -ny_c;
		mx_c   = nx_c[NW-1] ? nxn_c : nx_c;
		my_c   = ny_c[NW-1] ? nyn_c : ny_c;
		detn_c = -det_s3;
		if (inv_c)
			dmag_c = det_s3[SW-1] ? detn_c[DW-1:0] : det_s3[DW-1:0];
		else
			dmag_c = DW'(1) << FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			kind_s1 <= uop.kind;
			last_s1 <= uop.last;
			a0x_s1 <= a0x; b0x_s1 <= b0x; a1x_s1 <= a1x; b1x_s1 <= b1x;
			a0y_s1 <= a0y; b0y_s1 <= b0y; a1y_s1 <= a1y; b1y_s1 <= b1y;
			cx_s1  <= cx;
			cy_s1  <= cy;

			kind_s2 <= kind_s1;
			last_s2 <= last_s1;
			p0x_s2  <= a0x_s1 * b0x_s1;
			p1x_s2  <= a1x_s1 * b1x_s1;
			p0y_s2  <= a0y_s1 * b0y_s1;
			p1y_s2  <= a1y_s1 * b1y_s1;
			pd0_s2  <= pxx * pyy;
			pd1_s2  <= nyx * pxy;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;

			kind_s3 <= kind_s2;
			last_s3 <= last_s2;
			sx_s3   <= {p0x_s2[PW-1], p0x_s2} + {p1x_s2[PW-1], p1x_s2} + cx_s2;
			sy_s3   <= {p0y_s2[PW-1], p0y_s2} + {p1y_s2[PW-1], p1y_s2} + cy_s2;
			det_s3  <= {pd0_s2[PW-1], pd0_s2} + {pd1_s2[PW-1], pd1_s2};

			last_s4 <= last_s3;
			negx_s4 <= nx_c[NW-1] ^ (inv_c && det_s3[SW-1]);
			negy_s4 <= ny_c[NW-1] ^ (inv_c && det_s3[SW-1]);
			sing_s4 <= inv_c && (det_s3 == '0);
			npx_s4  <= (RW'(mx_c) << 1) + RW'(dmag_c);
			npy_s4  <= (RW'(my_c) << 1) + RW'(dmag_c);
			d2_s4   <= {dmag_c, 1'b0};

			npx_s5  <= npx_s4;
			npy_s5  <= npy_s4;
			d2_s5   <= d2_s4;
		end
	end

	logic [STEPS-1:0] qx, qy;

	apt_div #(.RW(RW), .DW2(DW + 1), .STEPS(STEPS)) u_div_x (
		.clk (clk),
		.ce  (ce),
		.num (npx_s5),
		.den2(d2_s5),
		.quo (qx)
	);

	apt_div #(.RW(RW), .DW2(DW + 1), .STEPS(STEPS)) u_div_y (
		.clk (clk),
		.ce  (ce),
		.num (npy_s5),
		.den2(d2_s5),
		.quo (qy)
	);

	tag_t tag_d_s [STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STEPS; i++)
				tag_d_s[i] <= '0;
		end else if (ce) begin
			tag_d_s[0] <= tag_s5;
			for (int i = 1; i < STEPS; i++)
				tag_d_s[i] <= tag_d_s[i-1];
		end
	end

	tag_t        tf;
	logic [31:0] qxe, qye, xo, yo;

	always_comb begin
		tf  = tag_d_s[STEPS-1];
		qxe = {1'b0, qx};
		qye = {1'b0, qy};
		if (tf.sing)
			xo = '0;
		else if (tf.satx)
			xo = tf.negx ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else
			xo = tf.negx ? -qxe : qxe;
		if (tf.sing)
			yo = '0;
		else if (tf.saty)
			yo = tf.negy ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else
			yo = tf.negy ? -qye : qye;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (ce)
			m_tvalid <= tf.v;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			m_tdata <= {yo, xo};
			m_tuser <= tf.sing;
			m_tlast <= tf.last;
		end
	end

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("singular result carries nonzero data");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ce |=> $stable(v_s1) && $stable(tag_s5))
		else $error("pipeline moved during stall");

	a_inv_first: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && kind_s1 == UK_INV0 |-> !last_s1)
		else $error("first invert pair marked last");

endmodule
